// ----- sv/ptcf_pkg.sv -----
// Shared types, constants and helpers for the packet truncate / checksum fixup unit.
package ptcf_pkg;

  localparam int MAC_HDR_BYTES = 14;
  localparam int POS_W         = 11;
  localparam int SEEN_LIMIT    = 2047;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_UDP   = 2'd1;
  localparam logic [1:0] KIND_TCP   = 2'd2;

  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  typedef logic [POS_W-1:0] pos_t;

  // Rewrite context shared by all lanes.
  typedef struct packed {
    pos_t        cut;
    pos_t        t_start;
    pos_t        seg;
    logic [1:0]  kind;
    logic [15:0] ipcs;
    logic [15:0] trcs;
    logic        off_wr;
    logic [7:0]  off_byte;
  } ctx_t;

  // End-around carry fold of a ones-complement accumulator.
  function automatic logic [15:0] fold26(input logic [25:0] s);
    logic [16:0] a;
    logic [16:0] b;
    a = {1'b0, s[15:0]} + {7'b0, s[25:16]};
    b = {1'b0, a[15:0]} + {16'b0, a[16]};
    return b[15:0];
  endfunction

endpackage

// ----- sv/packet_truncate_checksum_fixup_unit.sv -----
// Top level: frame collection, header decode, checksum pass and truncated copy output.
// Sequence: after the frame_end item, a flush, the header read pass and the setup states
//   CALC1 to CALC4, then the checksum pass over the kept words and a finish state; the
//   copy words then follow one per cycle during the emit pass.
// Throughput: one frame word per cycle while collecting; the frame buffer's single
//   read port sets the length of the three passes. busy is high from frame end to copy done.
// Reset (synchronous, rst_n low): back to collecting, no bytes held, copy length 64.
// Results are one-cycle strobes on out_valid; the receiver cannot stall.
module packet_truncate_checksum_fixup_unit #(
  parameter int MAX_COPY_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_frame_end,
  output logic        out_valid,
  output logic [63:0] out_word,
  output logic [3:0]  out_count,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_copy_length
);
  import ptcf_pkg::*;

  localparam int STORE_WORDS = (MAX_COPY_BYTES + 7) / 8;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int MAX_CUT     = (MAX_COPY_BYTES < SEEN_LIMIT) ? MAX_COPY_BYTES : SEEN_LIMIT;

  localparam logic [3:0] ST_COLLECT = 4'd0;
  localparam logic [3:0] ST_FLUSH   = 4'd1;
  localparam logic [3:0] ST_HDR     = 4'd2;
  localparam logic [3:0] ST_CALC1   = 4'd3;
  localparam logic [3:0] ST_CALC2   = 4'd4;
  localparam logic [3:0] ST_CALC3   = 4'd5;
  localparam logic [3:0] ST_CALC4   = 4'd6;
  localparam logic [3:0] ST_SUM     = 4'd7;
  localparam logic [3:0] ST_FIN     = 4'd8;
  localparam logic [3:0] ST_EMIT    = 4'd9;

  localparam logic [7:0] HDR_LAST_WORD = 8'd10;

  logic [3:0]  state_r;
  pos_t        bytes_seen_r;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;
  logic [9:0]  copy_len_r;
  logic [3:0]  ihl_r;
  logic [7:0]  proto_r;
  logic        frag_r;
  logic [7:0]  offb_r;
  pos_t        t_r;
  pos_t        hdr_r;
  pos_t        copyc_r;
  pos_t        cut_r;
  pos_t        seg_r;
  logic [1:0]  kind_r;
  logic [7:0]  last_w_r;
  logic [25:0] ip_acc_r;
  logic [25:0] tr_acc_r;
  logic [15:0] ipcs_r;
  logic [15:0] trcs_r;
  logic        off_wr_r;
  logic [7:0]  offn_r;
  logic [7:0]  rd_k_r;
  logic        iss_done_r;
  logic        rv_r;
  logic [7:0]  rk_r;
  logic        out_valid_r;
  logic [63:0] out_word_r;
  logic [3:0]  out_count_r;
  logic        out_last_r;

  // collection datapath
  logic         accept;
  logic [3:0]   n_in;
  pos_t         room;
  logic [3:0]   n_eff;
  logic [63:0]  keep;
  logic [127:0] merged;
  logic [3:0]   total;
  logic [7:0]   wr_idx;
  logic         in_range;

  // store ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [63:0]   rdata;

  logic          pass;
  logic [7:0]    limit;
  logic          pass_end;

  ctx_t          ctx;
  logic [15:0]   lane_out [4];
  logic [15:0]   lane_ip  [4];
  logic [15:0]   lane_tr  [4];
  logic [17:0]   ip_add;
  logic [17:0]   tr_add;

  // header decode
  pos_t        tt;
  logic [3:0]  off;
  logic [3:0]  thw;
  logic        drop;
  pos_t        copyc;
  pos_t        cut_max;
  pos_t        rem;
  logic [15:0] ts;
  logic [15:0] tc;
  logic [25:0] tr_total;

  assign busy      = state_r != ST_COLLECT;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_comb begin
    n_in     = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
    room     = pos_t'(SEEN_LIMIT) - bytes_seen_r;
    n_eff    = (room < {7'b0, n_in}) ? room[3:0] : n_in;
    keep     = ~({64{1'b1}} >> {n_eff, 3'b000});
    merged   = {acc_r, 64'h0} | ({in_data_word & keep, 64'h0} >> {bytes_seen_r[2:0], 3'b000});
    total    = {1'b0, bytes_seen_r[2:0]} + n_eff;
    wr_idx   = bytes_seen_r[10:3];
    in_range = 32'(wr_idx) < STORE_WORDS;
    acc_nxt  = total[3] ? merged[63:0] : merged[127:64];
  end

  always_comb begin
    we    = 1'b0;
    wdata = acc_r;
    if (state_r == ST_COLLECT && accept && total[3] && in_range) begin
      we    = 1'b1;
      wdata = merged[127:64];
    end else if (state_r == ST_FLUSH && bytes_seen_r[2:0] != 3'd0 && in_range) begin
      we = 1'b1;
    end
    waddr = AW'(wr_idx);
  end

  // the three read passes over the buffer share one issue counter
  assign pass     = state_r == ST_HDR || state_r == ST_SUM || state_r == ST_EMIT;
  assign limit    = (state_r == ST_HDR) ? HDR_LAST_WORD : last_w_r;
  assign re       = pass && !iss_done_r;
  assign raddr    = AW'(rd_k_r);
  assign pass_end = iss_done_r && !rv_r;

  ptcf_store #(.DEPTH(STORE_WORDS), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    ctx.cut      = cut_r;
    ctx.t_start  = t_r;
    ctx.seg      = seg_r;
    ctx.kind     = kind_r;
    ctx.ipcs     = ipcs_r;
    ctx.trcs     = trcs_r;
    ctx.off_wr   = off_wr_r;
    ctx.off_byte = offn_r;
  end

  // four pair lanes per buffer word
  for (genvar j = 0; j < 4; j++) begin : g_lane
    ptcf_lane u_lane (
      .pos      ({rk_r, 2'(j), 1'b0}),
      .pair_in  (rdata[63-16*j -: 16]),
      .ctx      (ctx),
      .zero_cs  (state_r != ST_EMIT),
      .pair_out (lane_out[j]),
      .ip_term  (lane_ip[j]),
      .tr_term  (lane_tr[j])
    );
  end

  // merge: add the lane terms
  always_comb begin
    ip_add = 18'(lane_ip[0]) + 18'(lane_ip[1]) + 18'(lane_ip[2]) + 18'(lane_ip[3]);
    tr_add = 18'(lane_tr[0]) + 18'(lane_tr[1]) + 18'(lane_tr[2]) + 18'(lane_tr[3]);
  end

  always_comb begin
    tt    = pos_t'(MAC_HDR_BYTES) + {5'b0, ihl_r, 2'b00};
    off   = offb_r[7:4];
    thw   = (off < 4'd5) ? 4'd5 : off;
    drop  = bytes_seen_r < pos_t'(34) || ihl_r < 4'd5 || bytes_seen_r < tt ||
            (proto_r == PROTO_UDP && bytes_seen_r < pos_t'(tt + pos_t'(8))) ||
            (proto_r == PROTO_TCP && bytes_seen_r < pos_t'(tt + pos_t'(20)));
    copyc = (copy_len_r < 10'd64) ? pos_t'(64) : {1'b0, copy_len_r};
    if (copyc > pos_t'(MAX_CUT)) begin
      copyc = pos_t'(MAX_CUT);
    end
    cut_max  = (copyc_r > hdr_r) ? copyc_r : hdr_r;
    rem      = cut_r - {rk_r, 3'b000};
    tr_total = tr_acc_r + 26'(seg_r) + ((kind_r == KIND_UDP) ? 26'(PROTO_UDP) : 26'(PROTO_TCP));
    ts       = fold26(tr_total);
    tc       = ~ts;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_COLLECT;
      bytes_seen_r <= '0;
      acc_r        <= '0;
      copy_len_r   <= 10'd64;
      rd_k_r       <= '0;
      iss_done_r   <= 1'b0;
      rv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        copy_len_r <= cfg_copy_length;
      end
      rv_r        <= re;
      rk_r        <= rd_k_r;
      out_valid_r <= rv_r && state_r == ST_EMIT;

      if (re) begin
        if (rd_k_r == limit) begin
          iss_done_r <= 1'b1;
        end else begin
          rd_k_r <= rd_k_r + 8'd1;
        end
      end
      if (pass && pass_end) begin
        rd_k_r     <= '0;
        iss_done_r <= 1'b0;
      end

      case (state_r)
        ST_COLLECT: begin
          if (accept) begin
            acc_r        <= acc_nxt;
            bytes_seen_r <= bytes_seen_r + {7'b0, n_eff};
            if (in_frame_end) begin
              state_r <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          state_r <= ST_HDR;
        end
        ST_HDR: begin
          if (rv_r) begin
            // IHL is the low nibble of byte 14
            if (rk_r == 8'd1) begin
              ihl_r <= rdata[11:8];
            end
            if (rk_r == 8'd2) begin
              proto_r <= rdata[7:0];
              frag_r  <= rdata[29:16] != 14'd0;
            end
            for (int i = 0; i < 8; i++) begin
              if ({rk_r, 3'(i)} == pos_t'(pos_t'(26) + {5'b0, ihl_r, 2'b00})) begin
                offb_r <= rdata[63-8*i -: 8];
              end
            end
          end
          if (pass_end) begin
            state_r <= ST_CALC1;
          end
        end
        ST_CALC1: begin
          t_r     <= tt;
          copyc_r <= copyc;
          if (proto_r == PROTO_UDP) begin
            kind_r <= KIND_UDP;
            hdr_r  <= pos_t'(tt + pos_t'(8));
          end else if (proto_r == PROTO_TCP) begin
            kind_r <= KIND_TCP;
            hdr_r  <= pos_t'(tt + {5'b0, thw, 2'b00});
          end else begin
            kind_r <= KIND_OTHER;
            hdr_r  <= tt;
          end
          if (drop) begin
            state_r      <= ST_COLLECT;
            bytes_seen_r <= '0;
            acc_r        <= '0;
          end else begin
            state_r <= ST_CALC2;
          end
        end
        ST_CALC2: begin
          cut_r   <= (cut_max > bytes_seen_r) ? bytes_seen_r : cut_max;
          state_r <= ST_CALC3;
        end
        ST_CALC3: begin
          seg_r    <= cut_r - t_r;
          last_w_r <= 8'(pos_t'(cut_r - pos_t'(1)) >> 3);
          ip_acc_r <= '0;
          tr_acc_r <= '0;
          state_r  <= ST_CALC4;
        end
        ST_CALC4: begin
          // TCP data offset fixup: raise small values, clamp to the kept segment in unfragmented frames
          if (off < 4'd5) begin
            off_wr_r <= 1'b1;
            offn_r   <= {4'd5, offb_r[3:0]};
          end else if ({5'b0, off, 2'b00} > seg_r && !frag_r) begin
            off_wr_r <= 1'b1;
            offn_r   <= {seg_r[5:2], offb_r[3:0]};
          end else begin
            off_wr_r <= 1'b0;
            offn_r   <= offb_r;
          end
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          if (rv_r) begin
            ip_acc_r <= ip_acc_r + 26'(ip_add);
            tr_acc_r <= tr_acc_r + 26'(tr_add);
          end
          if (pass_end) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          ipcs_r  <= ~fold26(ip_acc_r);
          // UDP sends a zero checksum as all ones
          trcs_r  <= (kind_r == KIND_UDP && tc == 16'h0) ? 16'hFFFF : tc;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (pass_end) begin
            state_r      <= ST_COLLECT;
            bytes_seen_r <= '0;
            acc_r        <= '0;
          end
        end
        default: begin
          state_r <= ST_COLLECT;
        end
      endcase
    end
  end

  // output register: rewritten, cut-masked word
  always_ff @(posedge clk) begin
    out_word_r  <= {lane_out[0], lane_out[1], lane_out[2], lane_out[3]};
    out_count_r <= (rem > pos_t'(8)) ? 4'd8 : rem[3:0];
    out_last_r  <= rk_r == last_w_r;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;

  a_busy_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("copy word while collecting");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count >= 4'd1 && out_count <= 4'd8)) else $error("bad out_count");
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid) else $error("gap in copy burst");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("word after last");

endmodule

// ----- sv/ptcf_store.sv -----
// Frame buffer: one write port, one registered read port.
module ptcf_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);
  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- sv/ptcf_lane.sv -----
// One 16-bit lane: field rewrite, cut masking and checksum terms for one byte pair.
module ptcf_lane (
  input  ptcf_pkg::pos_t  pos,
  input  logic [15:0]     pair_in,
  input  ptcf_pkg::ctx_t  ctx,
  input  logic            zero_cs,
  output logic [15:0]     pair_out,
  output logic [15:0]     ip_term,
  output logic [15:0]     tr_term
);
  import ptcf_pkg::*;

  logic [15:0] v;
  logic        hi_ok;
  logic        lo_ok;
  logic [15:0] m;

  always_comb begin
    v = pair_in;
    if (pos == pos_t'(16)) begin
      v = 16'(ctx.cut - pos_t'(MAC_HDR_BYTES));
    end else if (pos == pos_t'(24)) begin
      v = zero_cs ? 16'h0 : ctx.ipcs;
    end else if (ctx.kind == KIND_UDP && pos == pos_t'(ctx.t_start + pos_t'(4))) begin
      v = {5'b0, ctx.seg};
    end else if (ctx.kind == KIND_UDP && pos == pos_t'(ctx.t_start + pos_t'(6))) begin
      v = zero_cs ? 16'h0 : ctx.trcs;
    end else if (ctx.kind == KIND_TCP && ctx.off_wr &&
                 pos == pos_t'(ctx.t_start + pos_t'(12))) begin
      v = {ctx.off_byte, pair_in[7:0]};
    end else if (ctx.kind == KIND_TCP && pos == pos_t'(ctx.t_start + pos_t'(16))) begin
      v = zero_cs ? 16'h0 : ctx.trcs;
    end
    hi_ok = pos < ctx.cut;
    lo_ok = pos_t'(pos + pos_t'(1)) < ctx.cut;
    m = {hi_ok ? v[15:8] : 8'h0, lo_ok ? v[7:0] : 8'h0};
    pair_out = m;
    ip_term  = (pos >= pos_t'(MAC_HDR_BYTES) && pos < ctx.t_start) ? v : 16'h0;
    // transport range plus the address words of the pseudo-header
    tr_term  = (ctx.kind != KIND_OTHER &&
                ((pos >= ctx.t_start && hi_ok) ||
                 (pos >= pos_t'(26) && pos < pos_t'(34)))) ? m : 16'h0;
  end
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the packet truncate / checksum fixup unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptcf_pkg::*;

  localparam int MAXB = 512;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_byte_count = 4'd0;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic [63:0] out_word;
  logic [3:0]  out_count;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_copy_length = 10'd64;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  count;
    logic        last;
  } copy_word_t;

  copy_word_t copy_words_due[$];
  int         errors = 0;
  int         frames_sent = 0;
  int         words_checked = 0;

  // Predictor state: our own image of the frame and the copy length register.
  logic [7:0]  pkt_bytes[MAXB];
  int unsigned pkt_len;
  logic [9:0]  copy_len_reg;

  // Burst pacing for the sender.
  int burst_left = 0;

  packet_truncate_checksum_fixup_unit #(.MAX_COPY_BYTES(MAXB)) uut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Checksum helpers over the predictor's byte image.
  function automatic int unsigned fold16(input int unsigned s);
    while (s >> 16) s = (s & 32'hFFFF) + (s >> 16);
    return s;
  endfunction

  function automatic int unsigned sum16(input int unsigned st, input int unsigned len);
    int unsigned s;
    int unsigned hi;
    int unsigned lo;
    s = 0;
    for (int unsigned i = 0; i < len; i += 2) begin
      hi = (st + i < MAXB) ? pkt_bytes[st + i] : 0;
      lo = (i + 1 < len && st + i + 1 < MAXB) ? pkt_bytes[st + i + 1] : 0;
      s += (hi << 8) | lo;
    end
    return fold16(s);
  endfunction

  function automatic void put_be16(input int unsigned pos, input int unsigned v);
    if (pos < MAXB) pkt_bytes[pos] = v[15:8];
    if (pos + 1 < MAXB) pkt_bytes[pos + 1] = v[7:0];
  endfunction

  // Add one input word to the image; on frame end, predict the copy words.
  function automatic void predict_copy(input logic [63:0] w, input logic [3:0] bc,
                                       input logic fe);
    int unsigned n, t, ipb, hdr, cut, seg, s, c, off, frag, ob, cp, nw, cnt;
    logic [7:0] proto;
    logic [1:0] kind;
    copy_word_t cw;
    n = (bc > 8) ? 8 : bc;
    for (int unsigned i = 0; i < n; i++) begin
      if (pkt_len < SEEN_LIMIT) begin
        if (pkt_len < MAXB) pkt_bytes[pkt_len] = w[63 - 8*i -: 8];
        pkt_len++;
      end
    end
    if (!fe) return;
    off = 0;
    // frames too short for their own headers give nothing
    if (pkt_len < MAC_HDR_BYTES + 20) begin
      pkt_len = 0;
      return;
    end
    ipb = (pkt_bytes[MAC_HDR_BYTES] & 8'h0F) * 4;
    if (ipb < 20 || pkt_len < MAC_HDR_BYTES + ipb) begin
      pkt_len = 0;
      return;
    end
    t = MAC_HDR_BYTES + ipb;
    proto = pkt_bytes[MAC_HDR_BYTES + 9];
    if (proto == PROTO_UDP) begin
      if (pkt_len < t + 8) begin
        pkt_len = 0;
        return;
      end
      kind = KIND_UDP;
      hdr = t + 8;
    end else if (proto == PROTO_TCP) begin
      if (pkt_len < t + 20) begin
        pkt_len = 0;
        return;
      end
      kind = KIND_TCP;
      off = pkt_bytes[t + 12] >> 4;
      hdr = t + ((off < 5) ? 5 : off) * 4;
    end else begin
      kind = KIND_OTHER;
      hdr = t;
    end
    cp = copy_len_reg;
    if (cp < 64) cp = 64;
    if (cp > MAXB) cp = MAXB;
    cut = (cp > hdr) ? cp : hdr;
    if (cut > pkt_len) cut = pkt_len;
    if (cut > MAXB) cut = MAXB;
    seg = cut - t;
    put_be16(MAC_HDR_BYTES + 2, cut - MAC_HDR_BYTES);
    if (kind == KIND_UDP) begin
      put_be16(t + 4, seg);
      put_be16(t + 6, 0);
      s = fold16(sum16(t, seg) + sum16(MAC_HDR_BYTES + 12, 8) + 17 + seg);
      c = ~s & 32'hFFFF;
      if (c == 0) c = 32'hFFFF;   // zero UDP checksum goes out as all ones
      put_be16(t + 6, c);
    end else if (kind == KIND_TCP) begin
      frag = ((pkt_bytes[MAC_HDR_BYTES + 6] << 8) | pkt_bytes[MAC_HDR_BYTES + 7])
             & 32'h3FFF;
      ob = pkt_bytes[t + 12] & 8'h0F;
      if (off < 5) pkt_bytes[t + 12] = 8'((5 << 4) | ob);
      else if (off * 4 > seg && frag == 0)
        pkt_bytes[t + 12] = 8'((((seg >> 2) & 4'hF) << 4) | ob);
      put_be16(t + 16, 0);
      s = fold16(sum16(t, seg) + sum16(MAC_HDR_BYTES + 12, 8) + 6 + seg);
      put_be16(t + 16, ~s & 32'hFFFF);
    end
    put_be16(MAC_HDR_BYTES + 10, 0);
    put_be16(MAC_HDR_BYTES + 10, ~sum16(MAC_HDR_BYTES, ipb) & 32'hFFFF);
    nw = (cut + 7) / 8;
    for (int unsigned k = 0; k < nw; k++) begin
      cnt = cut - 8*k;
      if (cnt > 8) cnt = 8;
      cw.word = '0;
      for (int unsigned i = 0; i < 8; i++)
        cw.word = {cw.word[55:0], (i < cnt) ? pkt_bytes[8*k + i] : 8'h00};
      cw.count = cnt[3:0];
      cw.last = (k + 1 == nw);
      copy_words_due.push_back(cw);
    end
    pkt_len = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is compared against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (copy_words_due.size() == 0) begin
        $display("%0t: unexpected copy word %h cnt %0d last %0b",
                 $time, out_word, out_count, out_last);
        errors++;
      end else begin
        copy_word_t e;
        e = copy_words_due.pop_front();
        words_checked++;
        if (out_word !== e.word) begin
          $display("%0t: out_word exp %h got %h", $time, e.word, out_word);
          errors++;
        end
        if (out_count !== e.count) begin
          $display("%0t: out_count exp %0d got %0d", $time, e.count, out_count);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: out_last exp %0b got %0b", $time, e.last, out_last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Send one item; sender runs in bursts with random gaps. start stays high
  // inside a burst; a gap or a drain takes it low.
  task automatic send_item(input logic [63:0] w, input logic [3:0] bc, input logic fe);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_data_word <= w;
    in_byte_count <= bc;
    in_frame_end <= fe;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_copy(w, bc, fe);
    if (fe) frames_sent++;
    @(negedge clk);
  endtask

  // Wait until all copy words are out and the unit has gone idle.
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (copy_words_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_copy_length(input logic [9:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_copy_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    copy_len_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send a frame image as words, of random widths when odd_widths is set.
  task automatic send_frame(input logic [7:0] fb[], input bit odd_widths);
    int unsigned pos, n;
    logic [63:0] w;
    pos = 0;
    while (pos < fb.size()) begin
      n = odd_widths ? $urandom_range(1, 8) : 8;
      if (n > fb.size() - pos) n = fb.size() - pos;
      w = $urandom();
      w = {w[31:0], 32'($urandom())};
      for (int unsigned i = 0; i < n; i++) w[63 - 8*i -: 8] = fb[pos + i];
      pos += n;
      // byte counts past 8 act as 8; they are sent only when the word is full
      send_item(w, (n == 8 && $urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                   : 4'(n), pos >= fb.size());
    end
  endtask

  // Frame with given protocol, IHL, TCP data offset, flags/fragment and length.
  function automatic void make_frame(ref logic [7:0] fb[], input int unsigned len,
                                     input logic [7:0] proto, input int unsigned ihl,
                                     input int unsigned doff, input logic [15:0] fragw);
    fb = new[len];
    foreach (fb[i]) fb[i] = 8'($urandom());
    if (len > 14) fb[14] = {fb[14][7:4], 4'(ihl)};
    if (len > 23) fb[23] = proto;
    if (len > 21) begin
      fb[20] = fragw[15:8];
      fb[21] = fragw[7:0];
    end
    if (len > 14 + ihl*4 + 12) fb[14 + ihl*4 + 12] = {4'(doff), fb[14 + ihl*4 + 12][3:0]};
  endfunction

  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [7:0] fb[];
    // extremes of the word fields, short frames, zero byte count
    send_item('1, 4'd8, 1'b0);
    send_item('0, 4'd0, 1'b0);
    send_item('0, 4'd1, 1'b1);                  // short frame: dropped
    make_frame(fb, 30, PROTO_UDP, 5, 5, 0); send_frame(fb, 0);   // below 34 bytes
    make_frame(fb, 60, PROTO_UDP, 4, 5, 0); send_frame(fb, 0);   // IHL below five
    make_frame(fb, 50, PROTO_TCP, 15, 5, 0); send_frame(fb, 0);  // short for IP header
    make_frame(fb, 40, PROTO_UDP, 5, 5, 0); send_frame(fb, 0);   // short for UDP
    make_frame(fb, 50, PROTO_TCP, 5, 5, 0); send_frame(fb, 0);   // short for TCP
    // good frames
    make_frame(fb, 42, PROTO_UDP, 5, 5, 0); send_frame(fb, 0);   // UDP, header only
    make_frame(fb, 80, PROTO_UDP, 7, 5, 0); send_frame(fb, 1);
    make_frame(fb, 80, PROTO_TCP, 5, 2, 0); send_frame(fb, 0);   // TCP offset below five
    make_frame(fb, 60, PROTO_TCP, 5, 15, 0); send_frame(fb, 0);  // offset past segment
    make_frame(fb, 60, PROTO_TCP, 5, 15, 16'h2000); send_frame(fb, 0); // MF fragment
    make_frame(fb, 60, PROTO_TCP, 5, 15, 16'h0001); send_frame(fb, 0); // offset fragment
    make_frame(fb, 80, 8'd1, 15, 5, 0); send_frame(fb, 0);      // other protocol
  endtask

  // UDP frames with payload tuned so the checksum comes out zero.
  task automatic test_udp_zero_sum();
    logic [7:0] fb[];
    int unsigned s;
    for (int k = 0; k < 2; k++) begin
      make_frame(fb, 64, PROTO_UDP, 5, 5, 0);
      // predict the fixed UDP sum with bytes 62,63 zeroed, then make it 0xFFFF
      for (int i = 0; i < 64; i++) pkt_bytes[i] = fb[i];
      pkt_bytes[38] = 8'h00; pkt_bytes[39] = 8'd30;
      pkt_bytes[40] = 8'h00; pkt_bytes[41] = 8'h00;
      pkt_bytes[62] = 8'h00; pkt_bytes[63] = 8'h00;
      s = fold16(sum16(34, 30) + sum16(26, 8) + 17 + 30);
      s = ~s & 32'hFFFF;
      fb[62] = s[15:8];
      fb[63] = s[7:0];
      pkt_len = 0;
      send_frame(fb, 0);
    end
  endtask

  // Frame past the buffer size with the copy length at its ceiling.
  task automatic test_long_frame();
    logic [7:0] fb[];
    make_frame(fb, 520, PROTO_UDP, 5, 5, 0);
    send_frame(fb, 0);
  endtask

  task automatic test_random(input int unsigned items);
    logic [7:0]  fb[];
    int unsigned sent_words, sel, len, ihl, doff;
    logic [7:0]  proto;
    sent_words = 0;
    while (sent_words < items) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        // noise: a few random words
        repeat ($urandom_range(1, 4)) begin
          send_item({32'($urandom()), 32'($urandom())}, 4'($urandom()),
                    1'($urandom_range(0, 3) == 0));
          sent_words++;
        end
      end else begin
        proto = (sel < 5) ? PROTO_UDP : (sel < 8) ? PROTO_TCP : 8'($urandom());
        ihl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
        doff = $urandom_range(0, 15);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                          : $urandom_range(34, 110);
        make_frame(fb, len, proto, ihl, doff,
                   ($urandom_range(0, 2) == 0) ? 16'($urandom()) : 16'h0);
        send_frame(fb, $urandom_range(0, 1));
        sent_words += (len + 7) / 8;
      end
    end
    // close off any partial frame left by noise
    send_item('0, 4'd0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  initial begin
    pkt_len = 0;
    copy_len_reg = 10'd64;
    foreach (pkt_bytes[i]) pkt_bytes[i] = 8'h00;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_udp_zero_sum();
    write_copy_length(10'd0);      // below minimum: acts as 64
    test_random(15);
    write_copy_length(10'd1023);   // above maximum: acts as 512
    test_long_frame();
    write_copy_length(10'($urandom_range(64, 200)));
    test_random(15);

    drain();
    $display("tb: %0d frames ended, %0d copy words checked, copy length varied 0..1023",
             frames_sent, words_checked);
    if (errors == 0 && copy_words_due.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule
